// ----- rtl/plv_pkg.sv -----
// Shared constants, types and helpers for the positional list block.
package plv_pkg;

    // List geometry
    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W    = (CNT_W > 5) ? CNT_W : 5;

    // Operation codes
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LOCATE = 2'd2;

    // Reported index when nothing was found
    localparam logic [4:0] NOT_FOUND = 5'h1F;

    // What one cell does at the next edge
    typedef enum logic [1:0] {
        C_HOLD  = 2'd0,
        C_LEFT  = 2'd1,   // take the entry of the cell before
        C_RIGHT = 2'd2,   // take the entry of the cell after
        C_LOAD  = 2'd3    // take the broadcast value
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     live;   // cell lies below the current length
    } t_cell_ctrl;

    // Low five bits of a widened count or index
    function automatic logic [4:0] low5(input logic [CMP_W-1:0] v);
        return v[4:0];
    endfunction

endpackage

// ----- rtl/plv_cell.sv -----
// One list cell: holds an entry, shifts with its neighbors, compares to the key.
module plv_cell (
    input  logic                              i_clk,
    input  plv_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [plv_pkg::DATA_W-1:0] i_left,
    input  logic signed [plv_pkg::DATA_W-1:0] i_right,
    input  logic signed [plv_pkg::DATA_W-1:0] i_value,
    output logic signed [plv_pkg::DATA_W-1:0] o_data,
    output logic                              o_match
);

    logic signed [plv_pkg::DATA_W-1:0] r_data;

    // Entry update from neighbor or broadcast value
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            plv_pkg::C_LEFT:  r_data <= i_left;
            plv_pkg::C_RIGHT: r_data <= i_right;
            plv_pkg::C_LOAD:  r_data <= i_value;
            default:          r_data <= r_data;
        endcase
    end

    assign o_data  = r_data;
    assign o_match = i_ctrl.live && (r_data == i_value);

endmodule

// ----- rtl/positional_list_insert_delete_locate_top.sv -----
// Top level of the positional list: command register, cell row and result register.
//
// Each operation first captures the beat in a command register; then, in the
// execute state, every cell compares its entry against the value and shifts,
// loads or holds in parallel, while a priority encoder over the cell match bits
// picks the first hit. The result lands in an output register; a new beat is
// accepted the cycle after. If a previous result has not been taken, the
// execute state waits for the output register to free up.
module positional_list_insert_delete_locate_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_kind,
    input  logic [4:0]                        i_position,
    input  logic signed [plv_pkg::DATA_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_success,
    output logic signed [4:0]                 o_found_index,
    output logic [4:0]                        o_length
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                             r_state, n_state;
    logic [1:0]                         r_kind;
    logic [4:0]                         r_pos;
    logic signed [plv_pkg::DATA_W-1:0]  r_value;
    logic [plv_pkg::CNT_W-1:0]          r_count, n_count;

    logic                               w_accept, w_go;
    logic [plv_pkg::CMP_W-1:0]          w_pos_x, w_cnt_x;
    logic                               w_is_ins, w_is_del, w_is_loc;
    logic                               w_ins_ok, w_del_ok;
    logic                               w_hit;
    logic [plv_pkg::IDX_W-1:0]          w_hit_idx;
    logic                               n_success;
    logic [4:0]                         n_found;

    plv_pkg::t_cell_ctrl                w_ctrl  [plv_pkg::CAPACITY];
    logic signed [plv_pkg::DATA_W-1:0]  w_data  [plv_pkg::CAPACITY];
    logic signed [plv_pkg::DATA_W-1:0]  w_left  [plv_pkg::CAPACITY];
    logic signed [plv_pkg::DATA_W-1:0]  w_right [plv_pkg::CAPACITY];
    logic [plv_pkg::CAPACITY-1:0]       w_match;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_go       = (r_state == S_EXEC) && (!o_out_valid || i_out_ready);

    // Command decode
    assign w_pos_x  = plv_pkg::CMP_W'(r_pos);
    assign w_cnt_x  = plv_pkg::CMP_W'(r_count);
    assign w_is_ins = (r_kind == plv_pkg::KIND_INSERT);
    assign w_is_del = (r_kind == plv_pkg::KIND_DELETE);
    assign w_is_loc = (r_kind == plv_pkg::KIND_LOCATE);
    assign w_ins_ok = (r_count < plv_pkg::CNT_W'(plv_pkg::CAPACITY)) && (w_pos_x <= w_cnt_x);
    assign w_del_ok = (w_pos_x < w_cnt_x);

    // Cell row with per-cell control
    for (genvar g = 0; g < plv_pkg::CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = r_value;
        end else begin : g_mid
            assign w_left[g] = w_data[g-1];
        end
        if (g == plv_pkg::CAPACITY - 1) begin : g_last
            assign w_right[g] = w_data[g];
        end else begin : g_body
            assign w_right[g] = w_data[g+1];
        end

        always_comb begin
            w_ctrl[g].live = (plv_pkg::CMP_W'(g) < w_cnt_x);
            w_ctrl[g].op   = plv_pkg::C_HOLD;
            if (w_go && w_is_ins && w_ins_ok) begin
                if (plv_pkg::CMP_W'(g) > w_pos_x) begin
                    w_ctrl[g].op = plv_pkg::C_LEFT;
                end else if (plv_pkg::CMP_W'(g) == w_pos_x) begin
                    w_ctrl[g].op = plv_pkg::C_LOAD;
                end
            end else if (w_go && w_is_del && w_del_ok) begin
                if (plv_pkg::CMP_W'(g) >= w_pos_x) begin
                    w_ctrl[g].op = plv_pkg::C_RIGHT;
                end
            end
        end

        plv_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl[g]),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_value (r_value),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    // First matching cell
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int k = plv_pkg::CAPACITY - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_hit     = 1'b1;
                w_hit_idx = plv_pkg::IDX_W'(k);
            end
        end
    end

    // Result and next length
    always_comb begin
        n_count   = r_count;
        n_success = 1'b0;
        n_found   = plv_pkg::NOT_FOUND;
        unique case (r_kind)
            plv_pkg::KIND_INSERT: begin
                n_success = w_ins_ok;
                if (w_ins_ok) n_count = r_count + 1'b1;
            end
            plv_pkg::KIND_DELETE: begin
                n_success = w_del_ok;
                if (w_del_ok) n_count = r_count - 1'b1;
            end
            plv_pkg::KIND_LOCATE: begin
                n_success = w_hit;
                if (w_hit) n_found = plv_pkg::low5(plv_pkg::CMP_W'(w_hit_idx));
            end
            default: ;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_EXEC;
            S_EXEC:  if (w_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_go) begin
                r_count     <= n_count;
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Command and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_pos   <= i_position;
            r_value <= i_value;
        end
        if (w_go) begin
            o_success     <= n_success;
            o_found_index <= n_found;
            o_length      <= plv_pkg::low5(plv_pkg::CMP_W'(n_count));
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= plv_pkg::CNT_W'(plv_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_is_ins && w_ins_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the list");

    a_fail_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_success) |-> (o_found_index == plv_pkg::NOT_FOUND))
        else $error("failed result carries an index");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted beat not executed");

    a_loc_static: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (w_is_loc || !(w_is_ins || w_is_del))) |=> (r_count == $past(r_count)))
        else $error("locate changed the length");

endmodule

// ----- verif/positional_list_insert_delete_locate_top_tb.sv -----
// Testbench for the positional list: directed table, random ops, scoreboard on a predictor.
module positional_list_insert_delete_locate_top_tb;

    // Opcode the block leaves unused
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1710;
    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT_BEAT = 400;

    typedef struct packed {
        logic       success;
        logic [4:0] found_index;
        logic [4:0] length;
    } t_list_outcome;

    typedef struct {
        logic [1:0]    kind;
        logic [4:0]    pos;
        logic [31:0]   val;
        int            reps;
        bit            typed;
        t_list_outcome outcome;
    } t_dir_row;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_in_valid    = 1'b0;
    logic [1:0]                        i_kind        = plv_pkg::KIND_INSERT;
    logic [4:0]                        i_position    = 5'd0;
    logic signed [plv_pkg::DATA_W-1:0] i_value       = '0;
    logic                              i_out_ready   = 1'b0;
    logic                              o_in_ready;
    logic                              o_out_valid;
    logic                              o_success;
    logic signed [4:0]                 o_found_index;
    logic [4:0]                        o_length;

    // Predictor state: list contents and length
    logic signed [plv_pkg::DATA_W-1:0] list_vals [plv_pkg::CAPACITY];
    int                                list_len = 0;

    t_list_outcome pending_outcomes [$];
    int            mismatch_count = 0;
    int            result_count   = 0;
    int            sent_count     = 0;
    int            cycle_count    = 0;

    // Directed steps: empty list, extremes, fill to full, then take apart
    t_dir_row directed_steps [25] = '{
        '{plv_pkg::KIND_LOCATE, 5'd0,  32'h0000_0000, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd0}},
        '{plv_pkg::KIND_DELETE, 5'd0,  32'h0000_0000, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd0}},
        '{KIND_UNUSED, 5'd31, 32'hFFFF_FFFF, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd0}},
        '{plv_pkg::KIND_INSERT, 5'd1,  32'h0000_0005, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd0}},
        '{plv_pkg::KIND_INSERT, 5'd0,  32'h8000_0000, 1,  1'b1, '{1'b1, plv_pkg::NOT_FOUND, 5'd1}},
        '{plv_pkg::KIND_INSERT, 5'd1,  32'h7FFF_FFFF, 1,  1'b1, '{1'b1, plv_pkg::NOT_FOUND, 5'd2}},
        '{plv_pkg::KIND_LOCATE, 5'd31, 32'h7FFF_FFFF, 1,  1'b1, '{1'b1, 5'd1, 5'd2}},
        '{plv_pkg::KIND_LOCATE, 5'd0,  32'h8000_0000, 1,  1'b1, '{1'b1, 5'd0, 5'd2}},
        '{plv_pkg::KIND_LOCATE, 5'd0,  32'h0000_0000, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd2}},
        '{plv_pkg::KIND_DELETE, 5'd2,  32'h0000_0000, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd2}},
        '{plv_pkg::KIND_INSERT, 5'd31, 32'h0000_0001, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd2}},
        '{plv_pkg::KIND_INSERT, 5'd3,  32'h0000_0001, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd2}},
        '{plv_pkg::KIND_INSERT, 5'd1,  32'h5A5A_5A5A, 14, 1'b0, '{1'b0, plv_pkg::NOT_FOUND, 5'd0}},
        '{plv_pkg::KIND_INSERT, 5'd0,  32'h0000_0001, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd16}},
        '{plv_pkg::KIND_INSERT, 5'd16, 32'h0000_0001, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd16}},
        '{plv_pkg::KIND_LOCATE, 5'd0,  32'h5A5A_5A5A, 1,  1'b1, '{1'b1, 5'd1,  5'd16}},
        '{plv_pkg::KIND_LOCATE, 5'd0,  32'h7FFF_FFFF, 1,  1'b1, '{1'b1, 5'd15, 5'd16}},
        '{KIND_UNUSED, 5'd0,  32'h0000_0000, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd16}},
        '{plv_pkg::KIND_DELETE, 5'd16, 32'h0000_0000, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd16}},
        '{plv_pkg::KIND_DELETE, 5'd15, 32'h0000_0000, 1,  1'b1, '{1'b1, plv_pkg::NOT_FOUND, 5'd15}},
        '{plv_pkg::KIND_DELETE, 5'd0,  32'h0000_0000, 1,  1'b1, '{1'b1, plv_pkg::NOT_FOUND, 5'd14}},
        '{plv_pkg::KIND_LOCATE, 5'd0,  32'h8000_0000, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd14}},
        '{plv_pkg::KIND_INSERT, 5'd14, 32'h0000_0000, 1,  1'b1, '{1'b1, plv_pkg::NOT_FOUND, 5'd15}},
        '{plv_pkg::KIND_LOCATE, 5'd7,  32'h0000_0000, 1,  1'b1, '{1'b1, 5'd14, 5'd15}},
        '{plv_pkg::KIND_DELETE, 5'd31, 32'h0000_0000, 1,  1'b1, '{1'b0, plv_pkg::NOT_FOUND, 5'd15}}
    };

    positional_list_insert_delete_locate_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_success     (o_success),
        .o_found_index (o_found_index),
        .o_length      (o_length)
    );

    // Clock, period 10
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one operation to the list copy and return the result it gives
    function automatic t_list_outcome apply_list_op(logic [1:0] kind, logic [4:0] pos,
                                                    logic signed [plv_pkg::DATA_W-1:0] val);
        t_list_outcome r;
        int            i;
        r.success     = 1'b0;
        r.found_index = plv_pkg::NOT_FOUND;
        case (kind)
            plv_pkg::KIND_INSERT: begin
                if (list_len < plv_pkg::CAPACITY && int'(pos) <= list_len) begin
                    for (i = list_len; i > int'(pos); i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[pos] = val;
                    list_len++;
                    r.success = 1'b1;
                end
            end
            plv_pkg::KIND_DELETE: begin
                if (int'(pos) < list_len) begin
                    for (i = int'(pos); i < list_len - 1; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len--;
                    r.success = 1'b1;
                end
            end
            plv_pkg::KIND_LOCATE: begin
                // scan from the top so the lowest hit wins
                for (i = list_len - 1; i >= 0; i--) begin
                    if (list_vals[i] == val) begin
                        r.success     = 1'b1;
                        r.found_index = 5'(i);
                    end
                end
            end
            default: ;
        endcase
        r.length = 5'(list_len);
        return r;
    endfunction

    // Idle cycles before a beat; every fourth stretch of 50 runs back to back
    function automatic int draw_gap(int n);
        if ((n / 50) % 4 == 3)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("ERROR result %0d: %s", result_count, what);
    endtask

    // Random operation; phases alternate between growing and shrinking the list
    task automatic pick_operation(input int n, output logic [1:0] kind,
                                  output logic [4:0] pos, output logic [31:0] val);
        int roll;
        bit grow;
        roll = $urandom_range(0, 99);
        grow = ((n / 120) % 2 == 0);
        if (roll < 4)
            kind = KIND_UNUSED;
        else if (roll < 30)
            kind = plv_pkg::KIND_LOCATE;
        else if (roll < (grow ? 80 : 45))
            kind = plv_pkg::KIND_INSERT;
        else
            kind = plv_pkg::KIND_DELETE;

        if ($urandom_range(0, 9) == 0)
            pos = 5'($urandom_range(0, 31));
        else if (kind == plv_pkg::KIND_INSERT)
            pos = 5'($urandom_range(0, list_len));
        else if (kind == plv_pkg::KIND_DELETE && list_len > 0)
            pos = 5'($urandom_range(0, list_len - 1));
        else
            pos = 5'($urandom_range(0, 31));

        // small values give duplicates and locate hits
        if (kind == plv_pkg::KIND_LOCATE && list_len > 0 && $urandom_range(0, 2) != 0)
            val = list_vals[$urandom_range(0, list_len - 1)];
        else if ($urandom_range(0, 1) == 1)
            val = 32'($urandom_range(0, 7)) - 32'd4;
        else
            val = $urandom;
    endtask

    // Offer one beat, wait for acceptance, record what it should give
    task automatic send_beat(logic [1:0] kind, logic [4:0] pos, logic [31:0] val,
                             bit typed, t_list_outcome typed_outcome);
        int            gap;
        t_list_outcome predicted;
        gap = draw_gap(sent_count);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predicted = apply_list_op(kind, pos, val);
        pending_outcomes.push_back(typed ? typed_outcome : predicted);
        sent_count++;
        @(negedge i_clk);
    endtask

    // Sender: reset, directed table, random operations, drain, verdict
    initial begin : stimulus
        int            r;
        int            n;
        logic [1:0]    kind;
        logic [4:0]    pos;
        logic [31:0]   val;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < 25; r++)
            for (n = 0; n < directed_steps[r].reps; n++)
                send_beat(directed_steps[r].kind, directed_steps[r].pos,
                          directed_steps[r].val, directed_steps[r].typed,
                          directed_steps[r].outcome);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pick_operation(n, kind, pos, val);
            send_beat(kind, pos, val, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("positional_list_insert_delete_locate_top: match");
        else
            $display("positional_list_insert_delete_locate_top: mismatch");
        $finish;
    end

    // Receiver: random stalls per result, one long hold-off to back up the input
    initial begin : result_sink
        int taken;
        int hold;
        taken = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = (taken == HOLD_AT_BEAT) ? LONG_HOLD : draw_gap(taken + 100);
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            taken++;
            @(negedge i_clk);
        end
    end

    // Scoreboard: each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_list_outcome want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = pending_outcomes.pop_front();
                if (o_success !== want.success)
                    report_mismatch($sformatf("success %b, want %b", o_success, want.success));
                if (o_found_index !== want.found_index)
                    report_mismatch($sformatf("found_index %h, want %h",
                                              o_found_index, want.found_index));
                if (o_length !== want.length)
                    report_mismatch($sformatf("length %0d, want %0d", o_length, want.length));
            end
            result_count++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("positional_list_insert_delete_locate_top: mismatch");
            $finish;
        end
    end

endmodule
